// File: design/prim_mst_pkg.sv
// ----------------------------------------------------------------------------
// prim_mst_pkg: shared types and constants
// Sizes, register indexes and the run request passed from the top level
// to the tree sequencer.
// ----------------------------------------------------------------------------
package prim_mst_pkg;

	localparam int MAX_VERTICES = 16;
	localparam int WEIGHT_BITS  = 16;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int VCNT_W       = $clog2(MAX_VERTICES + 1);
	localparam int ADDR_W       = 2 * VIDX_W;
	localparam int STORE_DEPTH  = MAX_VERTICES * MAX_VERTICES;

	localparam int CFG_DATA_W   = 16;
	localparam int CFG_IDX_W    = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_VERTEX  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NO_EDGE_WEIGHT = 2'd2;

	localparam logic [VIDX_W-1:0]      SOURCE_RESET  = '0;
	localparam logic [VCNT_W-1:0]      COUNT_RESET   = VCNT_W'(5);
	localparam logic [WEIGHT_BITS-1:0] NO_EDGE_RESET = WEIGHT_BITS'(9999);

	typedef struct packed {
		logic                   start;
		logic [VCNT_W-1:0]      n;
		logic [VIDX_W-1:0]      src;
		logic [WEIGHT_BITS-1:0] none_w;
	} run_cmd_t;

endpackage

// File: design/prim_minimum_spanning_tree.sv
// ----------------------------------------------------------------------------
// prim_minimum_spanning_tree: Prim MST over a loaded adjacency matrix
// Config registers, weight RAM and the Prim sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one matrix entry per request:
//   row_vertex, column_vertex, edge_weight. Entries are stored one per cycle while in_ready is high.
//   A request with final_entry set is stored and, for n of 2 or more, starts
//   the run over vertices 0..n-1 from source_vertex; in_ready stays low
//   until the run's results have all been handed to the output register.
//   Output channel (out_valid/out_ready) gives one request per non-source
//   vertex in index order; last_result marks the final one.
//   A run takes a start step, then per joined vertex a key scan and a row
//   relaxation one after the other (the single weight RAM read port and the
//   shared comparator set this), a last scan, then the output phase.
//   A stalled receiver holds the sequencer in its output phase; nothing
//   is lost. Config (cfg_we/cfg_index/cfg_wdata) is written while idle.
//   Reset returns the sequencer to idle and the registers to source 0,
//   count 5, no-edge weight 9999; the weight RAM is not cleared.
// ----------------------------------------------------------------------------
module prim_minimum_spanning_tree (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [prim_mst_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [prim_mst_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [prim_mst_pkg::VIDX_W-1:0]         row_vertex,
	input  logic [prim_mst_pkg::VIDX_W-1:0]         column_vertex,
	input  logic [prim_mst_pkg::WEIGHT_BITS-1:0]    edge_weight,
	input  logic                                    final_entry,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [prim_mst_pkg::VIDX_W-1:0]         tree_vertex,
	output logic [prim_mst_pkg::VIDX_W-1:0]         parent_vertex,
	output logic [prim_mst_pkg::WEIGHT_BITS-1:0]    joining_weight,
	output logic                                    reached,
	output logic                                    last_result
);

	localparam int VW = prim_mst_pkg::VIDX_W;
	localparam int CW = prim_mst_pkg::VCNT_W;
	localparam int WW = prim_mst_pkg::WEIGHT_BITS;

	logic [VW-1:0] source_vertex_q;
	logic [CW-1:0] vertex_count_q;
	logic [WW-1:0] no_edge_weight_q;

	logic [CW-1:0] n_clamp;
	logic [VW-1:0] src_eff;
	logic          busy;
	logic          in_acc;
	logic          rd_en;
	logic [prim_mst_pkg::ADDR_W-1:0] rd_addr;
	logic [WW-1:0] rd_data;
	prim_mst_pkg::run_cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_vertex_q  <= prim_mst_pkg::SOURCE_RESET;
			vertex_count_q   <= prim_mst_pkg::COUNT_RESET;
			no_edge_weight_q <= prim_mst_pkg::NO_EDGE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				prim_mst_pkg::REG_SOURCE_VERTEX:  source_vertex_q  <= cfg_wdata[VW-1:0];
				prim_mst_pkg::REG_VERTEX_COUNT:   vertex_count_q   <= cfg_wdata[CW-1:0];
				prim_mst_pkg::REG_NO_EDGE_WEIGHT: no_edge_weight_q <= cfg_wdata[WW-1:0];
				default: ;
			endcase
		end
	end

	// oversize counts saturate, out-of-range source falls back to vertex 0
	assign n_clamp = (vertex_count_q > CW'(prim_mst_pkg::MAX_VERTICES)) ?
		CW'(prim_mst_pkg::MAX_VERTICES) : vertex_count_q;
	assign src_eff = ({1'b0, source_vertex_q} >= n_clamp) ? '0 : source_vertex_q;

	assign in_ready = !busy;
	assign in_acc   = in_valid && in_ready;

	always_comb begin
		cmd.start  = in_acc && final_entry && (n_clamp >= CW'(2));
		cmd.n      = n_clamp;
		cmd.src    = src_eff;
		cmd.none_w = no_edge_weight_q;
	end

	prim_mst_ram #(
		.WIDTH (WW),
		.DEPTH (prim_mst_pkg::STORE_DEPTH)
	) u_weight_ram (
		.clk   (clk),
		.we    (in_acc),
		.waddr ({row_vertex, column_vertex}),
		.wdata (edge_weight),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	prim_mst_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.busy           (busy),
		.rd_en          (rd_en),
		.rd_addr        (rd_addr),
		.rd_data        (rd_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.tree_vertex    (tree_vertex),
		.parent_vertex  (parent_vertex),
		.joining_weight (joining_weight),
		.reached        (reached),
		.last_result    (last_result)
	);

endmodule

// File: design/prim_mst_ram.sv
// ----------------------------------------------------------------------------
// prim_mst_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module prim_mst_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/prim_mst_core.sv
// ----------------------------------------------------------------------------
// prim_mst_core: Prim sequencer with one shared weight comparator
// Scans keys for the cheapest open vertex, relaxes its matrix row from the
// weight RAM, then reports the tree through an output register.
// ----------------------------------------------------------------------------
module prim_mst_core (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  prim_mst_pkg::run_cmd_t                   cmd,
	output logic                                     busy,
	output logic                                     rd_en,
	output logic [prim_mst_pkg::ADDR_W-1:0]          rd_addr,
	input  logic [prim_mst_pkg::WEIGHT_BITS-1:0]     rd_data,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic [prim_mst_pkg::VIDX_W-1:0]          tree_vertex,
	output logic [prim_mst_pkg::VIDX_W-1:0]          parent_vertex,
	output logic [prim_mst_pkg::WEIGHT_BITS-1:0]     joining_weight,
	output logic                                     reached,
	output logic                                     last_result
);

	localparam int MAXV = prim_mst_pkg::MAX_VERTICES;
	localparam int VW   = prim_mst_pkg::VIDX_W;
	localparam int CW   = prim_mst_pkg::VCNT_W;
	localparam int WW   = prim_mst_pkg::WEIGHT_BITS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]    state_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] lastv_q;
	logic [VW-1:0] src_q;
	logic [WW-1:0] none_q;
	logic [WW-1:0] best_q;
	logic [VW-1:0] pick_q;
	logic          found_q;
	logic          upd_s1;
	logic [VW-1:0] y_s1;
	logic          out_valid_q;

	logic [WW-1:0] key_q    [MAXV];
	logic [VW-1:0] parent_q [MAXV];
	logic [MAXV-1:0] in_tree_q;

	logic [VW-1:0] sel;
	logic [VW-1:0] idx_lo;
	logic [WW-1:0] key_rd;
	logic [VW-1:0] par_rd;
	logic          tree_rd;
	logic [WW-1:0] cmp_a;
	logic [WW-1:0] cmp_b;
	logic          cmp_lt;
	logic          scan_hit;
	logic          scan_end;
	logic          found_nx;
	logic [VW-1:0] pick_nx;
	logic          idx_lt_n;
	logic          upd_hit;
	logic          out_load;
	logic          start;

	assign start  = (state_q == ST_IDLE) && cmd.start;
	assign idx_lo = idx_q[VW-1:0];
	assign sel    = (state_q == ST_UPD) ? y_s1 : idx_lo;
	assign key_rd  = key_q[sel];
	assign par_rd  = parent_q[sel];
	assign tree_rd = in_tree_q[sel];

	// shared comparator: scan min, row relaxation, reached test
	always_comb begin
		unique case (state_q)
			ST_SCAN: begin
				cmp_a = key_rd;
				cmp_b = best_q;
			end
			ST_UPD: begin
				cmp_a = rd_data;
				cmp_b = key_rd;
			end
			default: begin
				cmp_a = key_rd;
				cmp_b = none_q;
			end
		endcase
	end
	assign cmp_lt = cmp_a < cmp_b;

	assign scan_hit = (state_q == ST_SCAN) && !tree_rd && cmp_lt;
	assign scan_end = idx_q == (n_q - CW'(1));
	assign found_nx = found_q | scan_hit;
	assign pick_nx  = scan_hit ? idx_lo : pick_q;
	assign idx_lt_n = idx_q < n_q;

	assign rd_en   = (state_q == ST_UPD) && idx_lt_n;
	assign rd_addr = {pick_q, idx_lo};
	assign upd_hit = (state_q == ST_UPD) && upd_s1 && !tree_rd && cmp_lt;

	assign out_load = (state_q == ST_OUT) && idx_lt_n && (idx_lo != src_q) &&
		(!out_valid_q || out_ready);

	assign busy      = state_q != ST_IDLE;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			found_q     <= 1'b0;
			upd_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			in_tree_q   <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q   <= ST_SCAN;
						idx_q     <= '0;
						found_q   <= 1'b0;
						in_tree_q <= '0;
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						found_q <= 1'b0;
						idx_q   <= '0;
						if (found_nx) begin
							in_tree_q[pick_nx] <= 1'b1;
							state_q            <= ST_UPD;
						end else begin
							state_q <= ST_OUT;
						end
					end else begin
						found_q <= found_nx;
						idx_q   <= idx_q + CW'(1);
					end
				end
				ST_UPD: begin
					upd_s1 <= idx_lt_n;
					if (idx_lt_n) begin
						idx_q <= idx_q + CW'(1);
					end else begin
						// last row entry is relaxed this cycle
						state_q <= ST_SCAN;
						idx_q   <= '0;
					end
				end
				ST_OUT: begin
					if (!idx_lt_n) begin
						state_q <= ST_IDLE;
					end else if ((idx_lo == src_q) || out_load) begin
						idx_q <= idx_q + CW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= cmd.n;
			src_q  <= cmd.src;
			none_q <= cmd.none_w;
			best_q <= cmd.none_w;
			lastv_q <= ({1'b0, cmd.src} == (cmd.n - CW'(1))) ?
				(cmd.n - CW'(2)) : (cmd.n - CW'(1));
			for (int i = 0; i < MAXV; i++) begin
				key_q[i]    <= cmd.none_w;
				parent_q[i] <= '0;
			end
			key_q[cmd.src] <= '0;
		end
		if (state_q == ST_SCAN) begin
			if (scan_end) begin
				best_q <= none_q;
			end else if (scan_hit) begin
				best_q <= key_rd;
			end
			if (scan_hit) begin
				pick_q <= idx_lo;
			end
		end
		y_s1 <= idx_lo;
		if (upd_hit) begin
			key_q[y_s1]    <= rd_data;
			parent_q[y_s1] <= pick_q;
		end
		if (out_load) begin
			tree_vertex    <= idx_lo;
			reached        <= cmp_lt;
			parent_vertex  <= cmp_lt ? par_rd : '0;
			joining_weight <= cmp_lt ? key_rd : '0;
			last_result    <= idx_q == lastv_q;
		end
	end

endmodule

// File: tb/prim_mst_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prim_mst_checker: spanning tree predictor and result scoreboard
// Mirrors the config registers and the weight matrix from the observed
// requests. Predicts the tree on every final entry and checks each output
// request against the oldest predicted tree edge.
// ----------------------------------------------------------------------------
module prim_mst_checker
	import prim_mst_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [VIDX_W-1:0]      row_vertex,
	input  logic [VIDX_W-1:0]      column_vertex,
	input  logic [WEIGHT_BITS-1:0] edge_weight,
	input  logic                   final_entry,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [VIDX_W-1:0]      tree_vertex,
	input  logic [VIDX_W-1:0]      parent_vertex,
	input  logic [WEIGHT_BITS-1:0] joining_weight,
	input  logic                   reached,
	input  logic                   last_result,
	output int                     err_count,
	output int                     pending,
	output int                     result_count
);

	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [VIDX_W-1:0]      vertex;
		logic [VIDX_W-1:0]      parent;
		logic [WEIGHT_BITS-1:0] weight;
		logic                   joined;
		logic                   is_last;
	} tree_edge_t;

	tree_edge_t edges_due_q[$];

	logic [VIDX_W-1:0]      root_cfg   = SOURCE_RESET;
	logic [VCNT_W-1:0]      count_cfg  = COUNT_RESET;
	logic [WEIGHT_BITS-1:0] absent_cfg = NO_EDGE_RESET;

	logic [WEIGHT_BITS-1:0] weights [MAX_VERTICES][MAX_VERTICES];
	logic [WEIGHT_BITS-1:0] key     [MAX_VERTICES];
	logic [VIDX_W-1:0]      link    [MAX_VERTICES];
	bit                     in_tree [MAX_VERTICES];

	task automatic predict_tree();
		int n, root, last_v, i, y, v, round, pick;
		bit found;
		logic [WEIGHT_BITS-1:0] best;
		tree_edge_t te;
		n = (count_cfg > MAX_VERTICES) ? MAX_VERTICES : int'(count_cfg);
		if (n >= 2) begin
			root = (int'(root_cfg) >= n) ? 0 : int'(root_cfg);
			for (i = 0; i < MAX_VERTICES; i++) begin
				key[i] = absent_cfg;
				link[i] = '0;
				in_tree[i] = 1'b0;
			end
			key[root] = '0;
			found = 1'b1;
			for (round = 0; round < n && found; round++) begin
				best = absent_cfg;
				pick = 0;
				found = 1'b0;
				// lowest index wins ties since only a strictly smaller key replaces
				for (i = 0; i < n; i++) begin
					if (!in_tree[i] && key[i] < best) begin
						best = key[i];
						pick = i;
						found = 1'b1;
					end
				end
				if (found) begin
					in_tree[pick] = 1'b1;
					for (y = 0; y < n; y++) begin
						if (!in_tree[y] && weights[pick][y] < key[y]) begin
							link[y] = VIDX_W'(pick);
							key[y] = weights[pick][y];
						end
					end
				end
			end
			last_v = (root == n - 1) ? n - 2 : n - 1;
			for (v = 0; v < n; v++) begin
				if (v != root) begin
					te.vertex = VIDX_W'(v);
					te.joined = (key[v] < absent_cfg);
					te.parent = te.joined ? link[v] : '0;
					te.weight = te.joined ? key[v] : '0;
					te.is_last = (v == last_v);
					edges_due_q.push_back(te);
				end
			end
		end
	endtask

	task automatic check_result();
		tree_edge_t want;
		result_count++;
		if (edges_due_q.size() == 0) begin
			if (err_count < MAX_REPORTS)
				$display("unexpected tree result: vertex %0d parent %0d weight %0d",
					tree_vertex, parent_vertex, joining_weight);
			err_count++;
		end else begin
			want = edges_due_q.pop_front();
			if (want.vertex !== tree_vertex || want.parent !== parent_vertex ||
					want.weight !== joining_weight || want.joined !== reached ||
					want.is_last !== last_result) begin
				if (err_count < MAX_REPORTS) begin
					$display("tree result mismatch: vertex exp %0d got %0d, parent exp %0d got %0d",
						want.vertex, tree_vertex, want.parent, parent_vertex);
					$display("  weight exp %0d got %0d, reached exp %0b got %0b, last exp %0b got %0b",
						want.weight, joining_weight, want.joined, reached,
						want.is_last, last_result);
				end
				err_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_cfg = SOURCE_RESET;
			count_cfg = COUNT_RESET;
			absent_cfg = NO_EDGE_RESET;
			edges_due_q.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SOURCE_VERTEX:  root_cfg = cfg_wdata[VIDX_W-1:0];
					REG_VERTEX_COUNT:   count_cfg = cfg_wdata[VCNT_W-1:0];
					REG_NO_EDGE_WEIGHT: absent_cfg = cfg_wdata[WEIGHT_BITS-1:0];
					default: ;
				endcase
			end
			// a final request can land on the same edge as the previous run's last result
			if (out_valid && out_ready)
				check_result();
			if (in_valid && in_ready) begin
				weights[row_vertex][column_vertex] = edge_weight;
				if (final_entry)
					predict_tree();
			end
			pending = edges_due_q.size();
		end
	end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench top for prim_minimum_spanning_tree
// Loads adjacency matrices request by request, fires tree runs under many
// register settings and idling patterns, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
	import prim_mst_pkg::*;

	localparam int SETTLE_CYCLES  = 600;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_ITEMS   = 246;
	localparam int LAST_BIG_GRAPH = 7;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;
	logic                   in_valid;
	logic                   in_ready;
	logic [VIDX_W-1:0]      row_vertex;
	logic [VIDX_W-1:0]      column_vertex;
	logic [WEIGHT_BITS-1:0] edge_weight;
	logic                   final_entry;
	logic                   out_valid;
	logic                   out_ready;
	logic [VIDX_W-1:0]      tree_vertex;
	logic [VIDX_W-1:0]      parent_vertex;
	logic [WEIGHT_BITS-1:0] joining_weight;
	logic                   reached;
	logic                   last_result;

	int err_count;
	int pending;
	int result_count;

	int idle_pct = 0;
	int stall_pct = 0;
	int items_sent = 0;
	int runs_done = 0;
	int quiet_cycles = 0;
	logic [WEIGHT_BITS-1:0] absent_w = NO_EDGE_RESET;
	bit loaded [MAX_VERTICES][MAX_VERTICES];

	prim_minimum_spanning_tree u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.row_vertex     (row_vertex),
		.column_vertex  (column_vertex),
		.edge_weight    (edge_weight),
		.final_entry    (final_entry),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.tree_vertex    (tree_vertex),
		.parent_vertex  (parent_vertex),
		.joining_weight (joining_weight),
		.reached        (reached),
		.last_result    (last_result)
	);

	prim_mst_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.row_vertex     (row_vertex),
		.column_vertex  (column_vertex),
		.edge_weight    (edge_weight),
		.final_entry    (final_entry),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.tree_vertex    (tree_vertex),
		.parent_vertex  (parent_vertex),
		.joining_weight (joining_weight),
		.reached        (reached),
		.last_result    (last_result),
		.err_count      (err_count),
		.pending        (pending),
		.result_count   (result_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no request accepted for %0d cycles", WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// all four register indexes, the spare one included, with junk above the used bits
	task automatic set_config(input int src, input int cnt, input int absent);
		cfg_we <= 1'b1;
		cfg_index <= REG_SOURCE_VERTEX;
		cfg_wdata <= {12'($urandom), 4'(src)};
		@(posedge clk);
		cfg_index <= REG_VERTEX_COUNT;
		cfg_wdata <= {11'($urandom), 5'(cnt)};
		@(posedge clk);
		cfg_index <= REG_NO_EDGE_WEIGHT;
		cfg_wdata <= 16'(absent);
		@(posedge clk);
		cfg_index <= REG_SPARE;
		cfg_wdata <= 16'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		absent_w = 16'(absent);
	endtask

	task automatic send_entry(input int r, input int c, input logic [WEIGHT_BITS-1:0] w,
			input logic fin);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		row_vertex <= VIDX_W'(r);
		column_vertex <= VIDX_W'(c);
		edge_weight <= w;
		final_entry <= fin;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		loaded[r][c] = 1'b1;
		items_sent++;
	endtask

	// waits out every predicted result, then the worst-case run time so that a
	// run with no results has surely finished before the next config write
	task automatic drain_results();
		in_valid <= 1'b0;
		runs_done++;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [WEIGHT_BITS-1:0] pick_weight(input logic [WEIGHT_BITS-1:0] absent);
		int sel;
		int hi;
		sel = $urandom_range(99);
		hi = int'(absent) - 1;
		if (absent == 0)
			return WEIGHT_BITS'($urandom);
		if (sel < 35)
			return WEIGHT_BITS'($urandom_range((hi < 15) ? hi : 15));
		if (sel < 60)
			return WEIGHT_BITS'($urandom_range(hi));
		if (sel < 75)
			return absent;
		if (sel < 85)
			return '1;
		return WEIGHT_BITS'($urandom);
	endfunction

	// random entries (a few outside the active square), then whatever of the
	// active square was never written, then the final entry
	task automatic send_graph(input int n_used, input int extra);
		int k, r, c;
		for (k = 0; k < extra; k++) begin
			if (n_used < MAX_VERTICES && $urandom_range(99) < 15) begin
				r = $urandom_range(MAX_VERTICES - 1);
				c = $urandom_range(MAX_VERTICES - 1);
			end else begin
				r = $urandom_range(n_used - 1);
				c = $urandom_range(n_used - 1);
			end
			send_entry(r, c, pick_weight(absent_w), 1'b0);
		end
		for (r = 0; r < n_used; r++)
			for (c = 0; c < n_used; c++)
				if (!loaded[r][c])
					send_entry(r, c, pick_weight(absent_w), 1'b0);
		send_entry($urandom_range(n_used - 1), $urandom_range(n_used - 1),
			pick_weight(absent_w), 1'b1);
		drain_results();
	endtask

	initial begin : stimulus
		int g, sel, src, cnt, absent, n_used, r, c, random_start;
		logic [WEIGHT_BITS-1:0] w;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SOURCE_VERTEX;
		cfg_wdata = '0;
		in_valid = 1'b0;
		row_vertex = '0;
		column_vertex = '0;
		edge_weight = '0;
		final_entry = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings; the root reaches nothing, so only row 0 is read
		send_entry(0, 0, '0, 1'b0);
		send_entry(0, 1, NO_EDGE_RESET, 1'b0);
		send_entry(0, 2, '1, 1'b0);
		send_entry(0, 3, 16'd10000, 1'b0);
		send_entry(0, 4, NO_EDGE_RESET, 1'b1);
		drain_results();

		// vertex counts below two give no results
		set_config(0, 0, 9999);
		send_entry(1, 1, 16'd5, 1'b1);
		drain_results();
		set_config(0, 1, 9999);
		send_entry(1, 0, 16'd5, 1'b1);
		drain_results();

		// zero no-edge weight: nothing can be picked, not even the root
		set_config(2, 3, 0);
		send_entry(15, 15, '1, 1'b1);
		drain_results();

		// root out of range falls back to 0; equal weights test the tie rule,
		// plus the largest present weight and an all-ones absent one
		set_config(15, 4, 65535);
		for (r = 0; r < 4; r++)
			for (c = 0; c < 4; c++) begin
				w = (r == c) ? '0 : 16'd7;
				if (r == 1 && c == 2)
					w = '1;
				if (r == 0 && c == 3)
					w = 16'hFFFE;
				send_entry(r, c, w, (r == 3 && c == 3));
			end
		drain_results();

		random_start = items_sent;
		g = 0;
		while (items_sent - random_start < RANDOM_ITEMS || g <= LAST_BIG_GRAPH) begin
			case ((g / 2) % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 55; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 55; end
				default: begin idle_pct = 29; stall_pct = 29; end
			endcase
			// mostly small graphs; the full matrix and saturated counts only a few times
			if (g == 4)
				cnt = MAX_VERTICES;
			else if (g == 6)
				cnt = $urandom_range(17, 30);
			else if (g == LAST_BIG_GRAPH)
				cnt = 31;
			else begin
				sel = $urandom_range(99);
				if (sel < 6)
					cnt = $urandom_range(1);
				else if (sel < 14)
					cnt = $urandom_range(7, 10);
				else
					cnt = $urandom_range(2, 6);
			end
			sel = $urandom_range(99);
			src = (sel < 20) ? 0 : (sel < 40) ? 15 : $urandom_range(15);
			sel = $urandom_range(99);
			if (sel < 6)
				absent = 0;
			else if (sel < 14)
				absent = 1;
			else if (sel < 30)
				absent = 65535;
			else if (sel < 60)
				absent = $urandom_range(2, 300);
			else
				absent = $urandom_range(1, 65535);
			set_config(src, cnt, absent);
			n_used = (cnt < 2) ? 2 : (cnt > MAX_VERTICES) ? MAX_VERTICES : cnt;
			send_graph(n_used, $urandom_range(n_used));
			g++;
		end

		$display("covered %0d matrix entries in %0d tree runs, %0d tree results checked",
			items_sent, runs_done, result_count);
		$display("vertex counts 0..31, roots 0..15, no-edge weights 0..65535, %0d mismatches",
			err_count);
		if (err_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
